// File: rtl/clrng_pkg.sv
`timescale 1ns / 1ps
// Shared constants of the combined congruential generator with shuffle table.
package clrng_pkg;

   localparam int VAL_W = 31;
   localparam int TABLE_DEPTH_DEF = 32;

   localparam logic [VAL_W-1:0] MOD1 = 31'd2147483563;
   localparam logic [VAL_W-1:0] MOD2 = 31'd2147483399;
   localparam logic [15:0] MUL1 = 16'd40014;
   localparam logic [15:0] MUL2 = 16'd40692;
   localparam logic [VAL_W-1:0] SPAN = 31'd2147483562;
   localparam logic [VAL_W-1:0] SEED_RESET = 31'd1234512345;
   localparam logic [VAL_W-1:0] SECOND_RESET = 31'd123456789;

endpackage

// File: rtl/clrng_lehmer.sv
`timescale 1ns / 1ps
// One multiplicative congruential step: multiply, then fold modulo 2^31 - d.
module clrng_lehmer import clrng_pkg::*; (
   input  logic             clock,
   input  logic             start,
   input  logic [VAL_W-1:0] z,
   input  logic [15:0]      multiplier,
   input  logic [VAL_W-1:0] modulus,
   output logic [VAL_W-1:0] result
);

   logic [VAL_W+15:0] prod_ff;
   logic [VAL_W+15:0] prod_in;
   logic [31:0]       diff_full;
   logic [7:0]        diff;
   logic [15:0]       hi;
   logic [VAL_W-1:0]  lo;
   logic [23:0]       fold;
   logic [31:0]       sum;
   logic [31:0]       reduced;

   assign prod_in = z * multiplier;

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
      end
   end

   // 2^31 is congruent to d, so fold the upper part back in with a small multiply
   assign diff_full = 32'h8000_0000 - {1'b0, modulus};
   assign diff      = diff_full[7:0];
   assign hi        = prod_ff[VAL_W+15:VAL_W];
   assign lo        = prod_ff[VAL_W-1:0];
   assign fold      = hi * diff;
   assign sum       = {1'b0, lo} + {8'd0, fold};
   assign reduced   = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
   assign result    = reduced[VAL_W-1:0];

endmodule

// File: rtl/clrng_bucket.sv
`timescale 1ns / 1ps
// Table index from the previous output: divide by the bucket size via a reciprocal.
module clrng_bucket import clrng_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int IW = 5
) (
   input  logic             clock,
   input  logic             start,
   input  logic [VAL_W-1:0] last_value,
   output logic [IW-1:0]    idx
);

   localparam longint unsigned BUCKET  = 64'd1 + 64'(SPAN) / TABLE_DEPTH;
   localparam longint unsigned RECIP   = 64'h1_0000_0000 / BUCKET;
   localparam int              RECIP_W = $clog2(RECIP + 1);
   localparam int              QW      = $clog2(TABLE_DEPTH + 1);
   localparam int              PW      = VAL_W + RECIP_W;

   logic [PW-1:0]    prod_ff;
   logic [PW-1:0]    prod_in;
   logic [VAL_W-1:0] x_ff;
   logic [VAL_W-1:0] x2_ff;
   logic [QW-1:0]    q_ff;
   logic [QW-1:0]    q_in;
   logic [31:0]      qb_ff;
   logic [31:0]      qb_in;
   logic [31:0]      rem;
   logic [QW-1:0]    q_fix;

   assign prod_in = PW'(last_value) * PW'(RECIP);

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
         x_ff    <= last_value;
      end
   end

   // estimate is the true quotient or one below it
   assign q_in  = QW'(prod_ff >> 32);
   assign qb_in = 32'(q_in * BUCKET);

   always_ff @(posedge clock) begin
      q_ff  <= q_in;
      qb_ff <= qb_in;
      x2_ff <= x_ff;
   end

   always_comb begin
      rem   = {1'b0, x2_ff} - qb_ff;
      q_fix = q_ff;
      if (rem >= 32'(BUCKET)) begin
         q_fix = q_ff + QW'(1);
      end
      if (q_fix > QW'(TABLE_DEPTH - 1)) begin
         q_fix = QW'(TABLE_DEPTH - 1);
      end
   end

   assign idx = IW'(q_fix);

endmodule

// File: rtl/clrng_table.sv
`timescale 1ns / 1ps
// Shuffle table: single-port write, registered read, entries read as zero until written.
module clrng_table import clrng_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int IW = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IW-1:0]    wr_addr,
   input  logic [VAL_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [IW-1:0]    rd_addr,
   output logic [VAL_W-1:0] rd_data
);

   logic [VAL_W-1:0]       table_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [VAL_W-1:0]       rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: rtl/combined_lcg_shuffle_rng_core.sv
`timescale 1ns / 1ps
// Combined congruential generator with shuffle table: one 31-bit value per draw beat,
// in 1..2147483562 (divide by 2147483563 for a uniform deviate). A draw beat is taken
// only while idle: the index divide and both generator steps run in CALC0, CALC1 and
// CALC2, then the shuffle table is read, and it is written back once the output register
// is free, so no new beat is taken before the last is through. A seed write arms a
// reseed; the next draw beat first runs TABLE_DEPTH+8 warm-up steps of the first
// generator, each one multiply and one modular fold. A beat with draw low is taken and
// dropped. Out of reset the table reads as zero and the generator runs unseeded until seeded.
module combined_lcg_shuffle_rng_core import clrng_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_draw,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] rsp_value,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [VAL_W-1:0] csr_seed
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int WW = $clog2(TABLE_DEPTH + 8);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_WARM_MUL  = 3'd1;
   localparam logic [2:0] ST_WARM_FOLD = 3'd2;
   localparam logic [2:0] ST_CALC0     = 3'd3;
   localparam logic [2:0] ST_CALC1     = 3'd4;
   localparam logic [2:0] ST_CALC2     = 3'd5;
   localparam logic [2:0] ST_READ      = 3'd6;

   logic [2:0]       state_ff,     state_in;
   logic [VAL_W-1:0] seed_ff,      seed_in;
   logic             pending_ff,   pending_in;
   logic [VAL_W-1:0] gen1_ff,      gen1_in;
   logic [VAL_W-1:0] gen2_ff,      gen2_in;
   logic [VAL_W-1:0] last_ff,      last_in;
   logic [WW-1:0]    warm_ff,      warm_in;
   logic [IW-1:0]    idx_ff,       idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;

   logic             gen1_start;
   logic             gen2_start;
   logic             bucket_start;
   logic [VAL_W-1:0] gen1_res;
   logic [VAL_W-1:0] gen2_res;
   logic [IW-1:0]    bucket_idx;
   logic             tbl_wr_en;
   logic [IW-1:0]    tbl_wr_addr;
   logic [VAL_W-1:0] tbl_wr_data;
   logic             tbl_rd_en;
   logic [IW-1:0]    tbl_rd_addr;
   logic [VAL_W-1:0] tbl_rd_data;
   logic [VAL_W-1:0] seed_eff;
   logic [31:0]      diff;
   logic [31:0]      diff_fix;
   logic [VAL_W-1:0] draw_value;
   logic             out_free;

   assign gen1_start   = (state_ff == ST_WARM_MUL) || (state_ff == ST_CALC0);
   assign gen2_start   = (state_ff == ST_CALC0);
   assign bucket_start = (state_ff == ST_CALC0);

   clrng_lehmer u_gen1 (
      .clock      (clock),
      .start      (gen1_start),
      .z          (gen1_ff),
      .multiplier (MUL1),
      .modulus    (MOD1),
      .result     (gen1_res)
   );

   clrng_lehmer u_gen2 (
      .clock      (clock),
      .start      (gen2_start),
      .z          (gen2_ff),
      .multiplier (MUL2),
      .modulus    (MOD2),
      .result     (gen2_res)
   );

   clrng_bucket #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IW          (IW)
   ) u_bucket (
      .clock      (clock),
      .start      (bucket_start),
      .last_value (last_ff),
      .idx        (bucket_idx)
   );

   clrng_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IW          (IW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign seed_eff = (seed_ff == '0) ? VAL_W'(1) : seed_ff;

   // entry minus second generator, folded into 1..SPAN
   always_comb begin
      diff     = {1'b0, tbl_rd_data} - {1'b0, gen2_ff};
      diff_fix = diff;
      if (diff[31] || (diff == '0)) begin
         diff_fix = diff + {1'b0, SPAN};
      end
   end

   assign draw_value = diff_fix[VAL_W-1:0];
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      pending_in   = pending_ff;
      gen1_in      = gen1_ff;
      gen2_in      = gen2_ff;
      last_in      = last_ff;
      warm_in      = warm_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      tbl_wr_en    = 1'b0;
      tbl_wr_addr  = idx_ff;
      tbl_wr_data  = gen1_ff;
      tbl_rd_en    = 1'b0;
      tbl_rd_addr  = bucket_idx;

      if (csr_valid) begin
         seed_in    = csr_seed;
         pending_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_draw) begin
               if (pending_ff) begin
                  gen1_in  = seed_eff;
                  gen2_in  = seed_eff;
                  warm_in  = WW'(TABLE_DEPTH + 7);
                  state_in = ST_WARM_MUL;
               end else begin
                  state_in = ST_CALC0;
               end
            end
         end
         ST_WARM_MUL: begin
            state_in = ST_WARM_FOLD;
         end
         ST_WARM_FOLD: begin
            gen1_in = gen1_res;
            if (warm_ff < WW'(TABLE_DEPTH)) begin
               tbl_wr_en   = 1'b1;
               tbl_wr_addr = IW'(warm_ff);
               tbl_wr_data = gen1_res;
            end
            if (warm_ff == '0) begin
               last_in    = gen1_res;
               pending_in = 1'b0;
               state_in   = ST_CALC0;
            end else begin
               warm_in  = warm_ff - WW'(1);
               state_in = ST_WARM_MUL;
            end
         end
         ST_CALC0: begin
            state_in = ST_CALC1;
         end
         ST_CALC1: begin
            gen1_in  = gen1_res;
            gen2_in  = gen2_res;
            state_in = ST_CALC2;
         end
         ST_CALC2: begin
            tbl_rd_en = 1'b1;
            idx_in    = bucket_idx;
            state_in  = ST_READ;
         end
         ST_READ: begin
            // hold the read data until the output register is free
            if (out_free) begin
               last_in      = draw_value;
               rsp_valid_in = 1'b1;
               rsp_value_in = draw_value;
               tbl_wr_en    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= SEED_RESET;
         pending_ff   <= 1'b0;
         gen1_ff      <= SEED_RESET;
         gen2_ff      <= SECOND_RESET;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         pending_ff   <= pending_in;
         gen1_ff      <= gen1_in;
         gen2_ff      <= gen2_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      warm_ff      <= warm_in;
      idx_ff       <= idx_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign csr_ready = 1'b1;

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value != '0) && (rsp_value <= SPAN))
      else $error("result outside 1..SPAN");

   a_gen_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC2) |-> (gen1_ff < MOD1) && (gen2_ff < MOD2))
      else $error("generator state not reduced");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC2) |-> ({1'b0, bucket_idx} < (IW + 1)'(TABLE_DEPTH)))
      else $error("table index beyond depth");

   a_warm_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WARM_FOLD) && (warm_ff == '0) |=> !pending_ff && (state_ff == ST_CALC0))
      else $error("reseed not retired after warm-up");

endmodule

// File: test/combined_lcg_shuffle_rng_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the combined congruential generator with shuffle table.
module combined_lcg_shuffle_rng_core_tb;
   import clrng_pkg::*;

   localparam int     SHUFFLE_DEPTH   = TABLE_DEPTH_DEF;
   localparam longint SCHRAGE_Q1      = 53668;
   localparam longint SCHRAGE_Q2      = 52774;
   localparam longint SCHRAGE_R1      = 12211;
   localparam longint SCHRAGE_R2      = 3791;
   localparam longint BUCKET_SIZE     = 1 + longint'(SPAN) / SHUFFLE_DEPTH;
   localparam int     HOLD_OFF_CYCLES = 400;
   localparam int     SETTLE_CYCLES   = 16;
   localparam int     STALL_LIMIT     = 3000;
   localparam int     RANDOM_PHASES   = 8;
   localparam int     DRAWS_PER_PHASE = 75;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_draw = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [VAL_W-1:0] rsp_value;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [VAL_W-1:0] csr_seed = '0;

   // generator state as the block should hold it
   logic [VAL_W-1:0] seed_reg = SEED_RESET;
   longint           gen_a = longint'(SEED_RESET);
   longint           gen_b = longint'(SECOND_RESET);
   longint           prev_value = 0;
   longint           shuffle [SHUFFLE_DEPTH];
   bit               reseed_armed = 1'b0;

   bit               pending_draws [$];
   logic [VAL_W-1:0] expected_values [$];
   int               fail_count = 0;
   int               send_gap = 0;
   int               rsp_wait = 0;
   int               hold_requests = 0;
   int               hold_served = 0;
   int               stuck_cycles = 0;
   bit               no_gaps = 1'b0;

   combined_lcg_shuffle_rng_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_draw  (req_draw),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_seed  (csr_seed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // a * z mod m without overflow, by Schrage's decomposition m = a * q + r
   function automatic longint schrage_mul(longint z, longint a, longint q, longint r,
                                          longint m);
      longint hi;
      longint t;
      hi = z / q;
      t = a * (z - hi * q) - hi * r;
      if (t < 0) t += m;
      return t;
   endfunction

   function automatic logic [VAL_W-1:0] next_random();
      longint s;
      longint slot;
      longint v;
      if (reseed_armed) begin
         s = longint'(seed_reg);
         if (s < 1) s = 1;
         gen_a = s;
         gen_b = s;
         // warm up, filling the table from the top down
         for (int w = SHUFFLE_DEPTH + 7; w >= 0; w--) begin
            gen_a = schrage_mul(gen_a, longint'(MUL1), SCHRAGE_Q1, SCHRAGE_R1,
                                longint'(MOD1));
            if (w < SHUFFLE_DEPTH) shuffle[w] = gen_a;
         end
         prev_value = shuffle[0];
         reseed_armed = 1'b0;
      end
      gen_a = schrage_mul(gen_a, longint'(MUL1), SCHRAGE_Q1, SCHRAGE_R1, longint'(MOD1));
      gen_b = schrage_mul(gen_b, longint'(MUL2), SCHRAGE_Q2, SCHRAGE_R2, longint'(MOD2));
      slot = prev_value / BUCKET_SIZE;
      if (slot < 0) slot = 0;
      if (slot > SHUFFLE_DEPTH - 1) slot = SHUFFLE_DEPTH - 1;
      v = shuffle[slot] - gen_b;
      shuffle[slot] = gen_a;
      if (v < 1) v += longint'(SPAN);
      prev_value = v;
      return v[VAL_W-1:0];
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VAL_W-1:0] pick_seed();
      if ($urandom_range(0, 99) < 25) begin
         case ($urandom_range(0, 4))
            0: return '0;
            1: return 31'd1;
            2: return MOD1;
            3: return MOD2;
            default: return '1;
         endcase
      end
      return VAL_W'($urandom());
   endfunction

   // sender: one beat in flight at a time, random gaps between beats
   always @(posedge clock) begin : sender
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready && req_draw) expected_values.push_back(next_random());
         if (req_valid && !req_ready) begin
            // hold the beat until taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_draws.size() != 0) begin
            req_valid <= 1'b1;
            req_draw <= pending_draws.pop_front();
            send_gap = (no_gaps || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: check each beat against the oldest expected value
   always @(posedge clock) begin : receiver
      logic [VAL_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               $error("value: no result expected, actual %0d", rsp_value);
               fail_count++;
            end else begin
               want = expected_values.pop_front();
               if (rsp_value !== want) begin
                  $error("value: expected %0d, actual %0d", want, rsp_value);
                  fail_count++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            rsp_wait = HOLD_OFF_CYCLES;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else if (no_gaps || $urandom_range(0, 99) < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rsp_wait = pick_gap() - 1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // drain everything, then let the block settle
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_draws.size() != 0 || req_valid || expected_values.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // keep valid high when another write follows straight on
   task automatic write_seed(input logic [VAL_W-1:0] value, input bit more);
      csr_seed <= value;
      if (!csr_valid) csr_valid <= 1'b1;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      seed_reg = value;
      reseed_armed = 1'b1;
      if (!more) csr_valid <= 1'b0;
   endtask

   task automatic queue_draws(input int count, input int low_pct);
      int taken;
      taken = 0;
      while (taken < count) begin
         if ($urandom_range(0, 99) < low_pct) begin
            pending_draws.push_back(1'b0);
         end else begin
            pending_draws.push_back(1'b1);
            taken++;
         end
      end
   endtask

   initial begin : stimulus
      for (int i = 0; i < SHUFFLE_DEPTH; i++) shuffle[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // unseeded draws straight out of reset, with dropped beats among them
      pending_draws.push_back(1'b1);
      pending_draws.push_back(1'b1);
      pending_draws.push_back(1'b0);
      pending_draws.push_back(1'b1);
      pending_draws.push_back(1'b0);
      pending_draws.push_back(1'b1);
      wait_idle();

      // zero seed acts as one; a dropped beat must not start the warm-up
      write_seed('0, 1'b0);
      pending_draws.push_back(1'b0);
      repeat (3) pending_draws.push_back(1'b1);
      wait_idle();

      // seeds equal to each modulus pin one generator at zero
      write_seed(MOD1, 1'b0);
      repeat (3) pending_draws.push_back(1'b1);
      wait_idle();
      write_seed(MOD2, 1'b0);
      repeat (3) pending_draws.push_back(1'b1);
      wait_idle();

      // seed above both moduli, then overwritten before any draw
      write_seed('1, 1'b1);
      write_seed(31'd1, 1'b0);
      repeat (2) pending_draws.push_back(1'b1);
      wait_idle();
      write_seed('1, 1'b0);
      repeat (2) pending_draws.push_back(1'b1);
      wait_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase % 4 != 3) write_seed(pick_seed(), 1'b0);
         no_gaps <= (phase == 2);
         if (phase == 4) hold_requests <= hold_requests + 1;
         if (phase == 5) begin
            // pause the sender mid-phase until every value is back
            queue_draws(DRAWS_PER_PHASE / 2, 8);
            wait_idle();
            queue_draws(DRAWS_PER_PHASE - DRAWS_PER_PHASE / 2, 8);
         end else begin
            queue_draws(DRAWS_PER_PHASE, 8);
         end
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
